// ----- rtl/trme_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trme_pkg
// Shared types and codes of the toy register machine executor.
// ----------------------------------------------------------------------------
package trme_pkg;

  localparam int StackDepthDef = 32;
  localparam int RegCount      = 26;
  localparam int ProgDepthDef  = 256;

  typedef enum logic [4:0] {
    OP_MOV  = 5'd0,  OP_INC = 5'd1,  OP_DEC = 5'd2,  OP_ADD = 5'd3,
    OP_SUB  = 5'd4,  OP_MUL = 5'd5,  OP_DIV = 5'd6,  OP_JMP = 5'd7,
    OP_CMP  = 5'd8,  OP_JNE = 5'd9,  OP_JE  = 5'd10, OP_JGE = 5'd11,
    OP_JG   = 5'd12, OP_JLE = 5'd13, OP_JL  = 5'd14, OP_CALL = 5'd15,
    OP_RET  = 5'd16, OP_MSG = 5'd17, OP_END = 5'd18
  } opcode_t;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_MSG    = 3'd1;
  localparam logic [2:0] ST_END    = 3'd2;
  localparam logic [2:0] ST_OVER   = 3'd3;
  localparam logic [2:0] ST_UNDER  = 3'd4;
  localparam logic [2:0] ST_DIVZ   = 3'd5;
  localparam logic [2:0] ST_HALTED = 3'd6;

  localparam logic [1:0] CMP_EQ = 2'd0;
  localparam logic [1:0] CMP_LT = 2'd1;
  localparam logic [1:0] CMP_GT = 2'd2;

  // Queue entry between front and back: one instruction.
  typedef struct packed {
    logic [4:0]  opcode;
    logic [4:0]  dest_reg;
    logic [4:0]  src_reg;
    logic        src_is_const;
    logic        first_is_const;
    logic [31:0] first_const;
    logic [31:0] src_const;
    logic [7:0]  target_pc;
  } instr_t;

  localparam int InstrW = $bits(instr_t);

endpackage
`default_nettype wire

// ----- rtl/trme_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trme_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module trme_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/trme_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trme_queue
// Two-entry instruction queue between front and back.
// ----------------------------------------------------------------------------
module trme_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire trme_pkg::instr_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output trme_pkg::instr_t       out_data
);
  trme_pkg::instr_t slot [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       push, pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slot[rptr];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      slot[wptr] <= in_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 2'd1)
    else $error("queue push not counted");
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) |-> !out_valid)
    else $error("empty queue shows data");
endmodule
`default_nettype wire

// ----- rtl/trme_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trme_divider
// Signed 32-bit restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module trme_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);
  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] rem, quo, dsr;
  logic        neg;
  logic [32:0] trial;

  assign trial = {rem[31:0], quo[31]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        rem  <= 32'd0;
        quo  <= dividend[31] ? (32'd0 - dividend) : dividend;
        dsr  <= divisor[31] ? (32'd0 - divisor) : divisor;
        neg  <= dividend[31] ^ divisor[31];
      end else if (busy) begin
        if (cnt == 6'd0) begin
          busy     <= 1'b0;
          done     <= 1'b1;
          quotient <= neg ? (32'd0 - quo) : quo;
        end else begin
          cnt <= cnt - 6'd1;
          if (!trial[32]) begin
            rem <= trial[31:0];
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= {rem[30:0], quo[31]};
            quo <= {quo[30:0], 1'b0};
          end
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (rst) busy |-> cnt <= 6'd32)
    else $error("divider count out of range");
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held");
endmodule
`default_nettype wire

// ----- rtl/trme_exec.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trme_exec
// Back end: executes one queued instruction on register file, flags and stack.
// ----------------------------------------------------------------------------
module trme_exec #(
  parameter int StackDepth = trme_pkg::StackDepthDef
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire trme_pkg::instr_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            out_next_pc,
  output logic [2:0]            out_status,
  output logic [31:0]           out_message
);
  localparam int ProgDepth = trme_pkg::ProgDepthDef;
  localparam int SaW = $clog2(StackDepth);
  localparam int SlW = $clog2(StackDepth + 1);
  localparam int PcW = $clog2(ProgDepth);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_POP, S_DIV, S_MUL, S_OUT} state_t;

  state_t           state;
  trme_pkg::instr_t ins;
  logic [31:0]      regs [trme_pkg::RegCount];
  logic [1:0]       cmp_res;
  logic [PcW-1:0]   pc;
  logic [SlW-1:0]   sp;
  logic             halted;
  logic [31:0]      d, s, first, prod;
  logic [PcW-1:0]   seq, target;
  logic             take;
  logic             div_start, div_done;
  logic [31:0]      div_q;
  logic             st_we;
  logic [SaW-1:0]   st_waddr, st_raddr;
  logic [PcW-1:0]   st_rdata;

  assign d = (ins.dest_reg < 5'd26) ? regs[ins.dest_reg] : 32'd0;
  assign s = ins.src_is_const ? ins.src_const :
             ((ins.src_reg < 5'd26) ? regs[ins.src_reg] : 32'd0);
  assign first  = ins.first_is_const ? ins.first_const : d;
  assign seq    = pc + PcW'(1);
  assign target = PcW'(ins.target_pc);
  assign in_ready  = (state == S_IDLE);
  assign div_start = (state == S_EXEC) && !halted && ins.opcode == trme_pkg::OP_DIV
                     && s != 32'd0;
  assign st_we    = (state == S_EXEC) && !halted && ins.opcode == trme_pkg::OP_CALL
                    && sp < SlW'(StackDepth);
  assign st_waddr = sp[SaW-1:0];
  assign st_raddr = SaW'(sp - SlW'(1));

  always_comb begin
    unique case (ins.opcode)
      trme_pkg::OP_JNE: take = cmp_res != trme_pkg::CMP_EQ;
      trme_pkg::OP_JE:  take = cmp_res == trme_pkg::CMP_EQ;
      trme_pkg::OP_JGE: take = cmp_res != trme_pkg::CMP_LT;
      trme_pkg::OP_JG:  take = cmp_res == trme_pkg::CMP_GT;
      trme_pkg::OP_JLE: take = cmp_res != trme_pkg::CMP_GT;
      trme_pkg::OP_JL:  take = cmp_res == trme_pkg::CMP_LT;
      trme_pkg::OP_JMP: take = 1'b1;
      default:          take = 1'b0;
    endcase
  end

  trme_ram #(.Width(PcW), .Depth(StackDepth)) u_stack (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(seq),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  trme_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(d), .divisor(s),
    .done(div_done), .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cmp_res   <= trme_pkg::CMP_EQ;
      pc        <= '0;
      sp        <= '0;
      halted    <= 1'b0;
      for (int i = 0; i < trme_pkg::RegCount; i++) begin
        regs[i] <= 32'd0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            ins   <= in_data;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          out_status  <= trme_pkg::ST_OK;
          out_message <= 32'd0;
          out_next_pc <= 8'(seq);
          state       <= S_OUT;
          if (halted) begin
            out_status  <= trme_pkg::ST_HALTED;
            out_next_pc <= 8'(pc);
          end else begin
            pc <= seq;
            unique case (ins.opcode)
              trme_pkg::OP_MOV: if (ins.dest_reg < 5'd26) regs[ins.dest_reg] <= s;
              trme_pkg::OP_INC: if (ins.dest_reg < 5'd26) regs[ins.dest_reg] <= d + 32'd1;
              trme_pkg::OP_DEC: if (ins.dest_reg < 5'd26) regs[ins.dest_reg] <= d - 32'd1;
              trme_pkg::OP_ADD: if (ins.dest_reg < 5'd26) regs[ins.dest_reg] <= d + s;
              trme_pkg::OP_SUB: if (ins.dest_reg < 5'd26) regs[ins.dest_reg] <= d - s;
              trme_pkg::OP_MUL: begin
                prod  <= d * s;
                state <= S_MUL;
              end
              trme_pkg::OP_DIV: begin
                if (s == 32'd0) begin
                  out_status  <= trme_pkg::ST_DIVZ;
                  out_next_pc <= 8'(pc);
                  pc          <= pc;
                end else begin
                  state <= S_DIV;
                end
              end
              trme_pkg::OP_CMP: begin
                if (first == s) begin
                  cmp_res <= trme_pkg::CMP_EQ;
                end else if ($signed(first) < $signed(s)) begin
                  cmp_res <= trme_pkg::CMP_LT;
                end else begin
                  cmp_res <= trme_pkg::CMP_GT;
                end
              end
              trme_pkg::OP_CALL: begin
                if (sp >= SlW'(StackDepth)) begin
                  out_status  <= trme_pkg::ST_OVER;
                  out_next_pc <= 8'(pc);
                  pc          <= pc;
                end else begin
                  sp          <= sp + SlW'(1);
                  pc          <= target;
                  out_next_pc <= 8'(target);
                end
              end
              trme_pkg::OP_RET: begin
                if (sp == '0) begin
                  out_status  <= trme_pkg::ST_UNDER;
                  out_next_pc <= 8'(pc);
                  pc          <= pc;
                end else begin
                  sp    <= sp - SlW'(1);
                  state <= S_POP;
                end
              end
              trme_pkg::OP_MSG: begin
                out_status  <= trme_pkg::ST_MSG;
                out_message <= d;
              end
              trme_pkg::OP_END: begin
                out_status  <= trme_pkg::ST_END;
                out_next_pc <= 8'(pc);
                pc          <= pc;
                halted      <= 1'b1;
              end
              default: begin
                if (take) begin
                  pc          <= target;
                  out_next_pc <= 8'(target);
                end
              end
            endcase
          end
          if (state != S_EXEC || !(ins.opcode == trme_pkg::OP_MUL)) begin
            out_valid <= 1'b0;
          end
        end
        S_POP: begin
          pc          <= st_rdata;
          out_next_pc <= 8'(st_rdata);
          state       <= S_OUT;
        end
        S_MUL: begin
          if (ins.dest_reg < 5'd26) regs[ins.dest_reg] <= prod;
          state <= S_OUT;
        end
        S_DIV: begin
          if (div_done) begin
            if (ins.dest_reg < 5'd26) regs[ins.dest_reg] <= div_q;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) sp <= SlW'(StackDepth))
    else $error("stack level above depth");
  assert property (@(posedge clk) disable iff (rst) out_valid |-> state == S_OUT)
    else $error("result shown outside output state");
  assert property (@(posedge clk) disable iff (rst)
    $rose(halted) |-> out_status == trme_pkg::ST_END)
    else $error("halt without end status");
endmodule
`default_nettype wire

// ----- rtl/toy_register_machine_executor.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// toy_register_machine_executor
// Executes one decoded instruction per item on 26 registers with a call stack.
// ----------------------------------------------------------------------------
// An item is taken into a two-entry queue as soon as there is room, and the
// execution unit works one instruction at a time: most instructions pass
// through queue, execute, output register and handshake; mul and ret also
// pass through the multiplier register or the stack RAM read, and div by a
// nonzero value waits for the one-bit-per-cycle divider.
module toy_register_machine_executor #(
  parameter int StackDepth = trme_pkg::StackDepthDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // opcode[4:0] dest_reg[9:5] src_reg[14:10] src_is_const[15]
  // first_is_const[16] first_const[48:17] src_const[80:49] target_pc[88:81]
  input  wire logic [95:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // next_pc[7:0] status[10:8] message_value[42:11]
  output logic [47:0]      m_tdata
);
  trme_pkg::instr_t in_ins, q_ins;
  logic             q_valid, q_ready;
  logic [7:0]       npc;
  logic [2:0]       status;
  logic [31:0]      msg;

  assign in_ins.opcode         = s_tdata[4:0];
  assign in_ins.dest_reg       = s_tdata[9:5];
  assign in_ins.src_reg        = s_tdata[14:10];
  assign in_ins.src_is_const   = s_tdata[15];
  assign in_ins.first_is_const = s_tdata[16];
  assign in_ins.first_const    = s_tdata[48:17];
  assign in_ins.src_const      = s_tdata[80:49];
  assign in_ins.target_pc      = s_tdata[88:81];

  trme_queue u_queue (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .in_data(in_ins), .out_valid(q_valid), .out_ready(q_ready), .out_data(q_ins)
  );

  trme_exec #(.StackDepth(StackDepth)) u_exec (
    .clk(clk), .rst(rst), .in_valid(q_valid), .in_ready(q_ready), .in_data(q_ins),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_next_pc(npc),
    .out_status(status), .out_message(msg)
  );

  assign m_tdata = {5'd0, msg, status, npc};
endmodule
`default_nettype wire
